// ----- rtl/itr_pkg.sv -----
// Shared types, codes and character constants for the integer to radix ASCII block.
// No dependencies; every other file refers to it by scoped names.
package itr_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam logic [2:0] FUNC_LIT = 3'd0;
  localparam logic [2:0] FUNC_DEC = 3'd1;
  localparam logic [2:0] FUNC_HEX = 3'd2;
  localparam logic [2:0] FUNC_BIN = 3'd3;
  localparam logic [2:0] FUNC_CHR = 3'd4;

  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;
  localparam logic [7:0] CHAR_LA       = 8'h61;
  localparam logic [7:0] CHAR_LF       = 8'h66;
  localparam logic [7:0] CHAR_MINUS    = 8'h2d;
  localparam logic [7:0] CHAR_X        = 8'h78;
  localparam logic [7:0] CHAR_B        = 8'h62;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd39;

  typedef enum logic [1:0] {
    KIND_CHR,
    KIND_DEC,
    KIND_HEX,
    KIND_BIN
  } itr_kind_t;

  typedef struct packed {
    itr_kind_t kind;
    logic      neg;
  } itr_cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    c = CHAR_ZERO + {4'd0, d};
    if (d > 4'd9) begin
      c = c + HEX_ALPHA_OFS;
    end
    return c;
  endfunction

endpackage

// ----- rtl/itr_if.sv -----
// Valid/ready channel interfaces for directive items and character items.
// Depends on itr_pkg for the default value width.
interface itr_in_if #(
  parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic [2:0]                   func;
  logic signed [VALUE_BITS-1:0] value;

  modport source(output valid, func, value, input ready);
  modport sink(input valid, func, value, output ready);
endinterface

interface itr_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_char;

  modport source(output valid, ascii_char, last_char, input ready);
  modport sink(input valid, ascii_char, last_char, output ready);
endinterface

// ----- rtl/integer_to_radix_ascii.sv -----
// Top level of the integer to radix ASCII converter: front end, queue, back end.
// Depends on itr_pkg, itr_if, itr_front, itr_queue and itr_back.
//
//   channel   dir  handshake     payload
//   in_item   in   valid/ready   func[2:0], value[VALUE_BITS-1:0] signed
//   out_item  out  valid/ready   ascii_char[7:0], last_char
//
// Output runs at one character per cycle while emitting and out_item.ready stays high.
// Per directive the back end first loads it from the queue, then for decimal runs
// shift-add-3 conversion over every input bit, then for numeric directives skips
// the leading zero digits one at a time and leaves the skip step, and then emits
// one character at a time; a char directive is just loaded and emitted.
// While out_item.ready stays low with an item waiting, the back end holds in its emitting states.
// The two-entry queue lets in_item accept up to two directives while the back end is busy.
// Reset is synchronous on rst_n and clears the queue, the back-end state and the output valid.
module integer_to_radix_ascii #(
  parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  itr_in_if.sink     in_item,
  itr_out_if.source  out_item
);

  logic                  q_full;
  logic                  q_push;
  itr_pkg::itr_cmd_t     q_push_cmd;
  logic [VALUE_BITS-1:0] q_push_mag;
  logic                  q_pop;
  logic                  q_valid;
  itr_pkg::itr_cmd_t     q_pop_cmd;
  logic [VALUE_BITS-1:0] q_pop_mag;

  itr_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_push_cmd),
    .q_mag   (q_push_mag)
  );

  itr_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .push_mag  (q_push_mag),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_pop_cmd),
    .pop_mag   (q_pop_mag)
  );

  itr_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_pop_cmd),
    .q_mag    (q_pop_mag),
    .q_pop    (q_pop),
    .out_item (out_item)
  );

endmodule

// ----- rtl/itr_front.sv -----
// Front end: accepts directive items, drops unused selectors, forms sign and magnitude.
// Depends on itr_pkg and itr_in_if; feeds itr_queue.
module itr_front #(
  parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
  itr_in_if.sink                  in_item,
  input  logic                    q_full,
  output logic                    q_push,
  output itr_pkg::itr_cmd_t       q_cmd,
  output logic [VALUE_BITS-1:0]   q_mag
);

  logic [VALUE_BITS-1:0] val_u;
  logic                  sel_ok;

  assign in_item.ready = !q_full;
  assign val_u         = VALUE_BITS'(in_item.value);

  always_comb begin
    sel_ok     = 1'b1;
    q_cmd.kind = itr_pkg::KIND_CHR;
    q_cmd.neg  = 1'b0;
    q_mag      = val_u;
    case (in_item.func)
      itr_pkg::FUNC_LIT, itr_pkg::FUNC_CHR: begin
        q_cmd.kind = itr_pkg::KIND_CHR;
      end
      itr_pkg::FUNC_DEC: q_cmd.kind = itr_pkg::KIND_DEC;
      itr_pkg::FUNC_HEX: q_cmd.kind = itr_pkg::KIND_HEX;
      itr_pkg::FUNC_BIN: q_cmd.kind = itr_pkg::KIND_BIN;
      default: sel_ok = 1'b0;
    endcase
    if (q_cmd.kind != itr_pkg::KIND_CHR) begin
      q_cmd.neg = val_u[VALUE_BITS-1];
      if (val_u[VALUE_BITS-1]) begin
        q_mag = ~val_u + VALUE_BITS'(1);
      end
    end
  end

  assign q_push = in_item.valid && !q_full && sel_ok;

endmodule

// ----- rtl/itr_queue.sv -----
// Two-entry queue of classified directives between front and back end.
// Depends on itr_pkg for the command struct.
module itr_queue #(
  parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  itr_pkg::itr_cmd_t     push_cmd,
  input  logic [VALUE_BITS-1:0] push_mag,
  output logic                  full,
  input  logic                  pop,
  output logic                  pop_valid,
  output itr_pkg::itr_cmd_t     pop_cmd,
  output logic [VALUE_BITS-1:0] pop_mag
);

  itr_pkg::itr_cmd_t     cmd_mem [2];
  logic [VALUE_BITS-1:0] mag_mem [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_cmd   = cmd_mem[rd_ptr_r];
  assign pop_mag   = mag_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_mem[wr_ptr_r] <= push_cmd;
      mag_mem[wr_ptr_r] <= push_mag;
    end
  end

endmodule

// ----- rtl/itr_back.sv -----
// Back end: converts one directive to characters and drives the output register.
// Depends on itr_pkg and itr_out_if; fed by itr_queue.
module itr_back #(
  parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  itr_pkg::itr_cmd_t     q_cmd,
  input  logic [VALUE_BITS-1:0] q_mag,
  output logic                  q_pop,
  itr_out_if.source             out_item
);

  localparam int NDEC = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int NHEX = (VALUE_BITS + 3) / 4;
  localparam int HW   = 4 * NHEX;
  localparam int SW   = 4 * NDEC;
  localparam int CW   = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_PFX0 = 3'd4;
  localparam logic [2:0] S_PFX1 = 3'd5;
  localparam logic [2:0] S_DIG  = 3'd6;
  localparam logic [2:0] S_CHR  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  itr_pkg::itr_kind_t    kind_r, kind_nxt;
  logic                  neg_r, neg_nxt;
  logic [SW-1:0]         sh_r, sh_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic [7:0]            out_char_r;
  logic                  out_last_r;

  logic                  can_emit;
  logic                  emit;
  logic [7:0]            emit_char;
  logic                  emit_last;
  logic [3:0]            cur_dig;
  logic [SW-1:0]         sh_shift;
  logic [SW-1:0]         adj;

  assign can_emit = !out_vld_r || out_item.ready;
  assign cur_dig  = (kind_r == itr_pkg::KIND_BIN) ? {3'd0, sh_r[SW-1]} : sh_r[SW-1 -: 4];
  assign sh_shift = (kind_r == itr_pkg::KIND_BIN) ? (sh_r << 1) : (sh_r << 4);

  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      adj[4*i +: 4] = (sh_r[4*i +: 4] >= 4'd5) ? (sh_r[4*i +: 4] + 4'd3) : sh_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    neg_nxt   = neg_r;
    sh_nxt    = sh_r;
    bin_nxt   = bin_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_char = itr_pkg::CHAR_ZERO;
    emit_last = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          kind_nxt = q_cmd.kind;
          neg_nxt  = q_cmd.neg;
          case (q_cmd.kind)
            itr_pkg::KIND_CHR: begin
              sh_nxt    = SW'(q_mag);
              state_nxt = S_CHR;
            end
            itr_pkg::KIND_DEC: begin
              sh_nxt    = '0;
              bin_nxt   = q_mag;
              cnt_nxt   = CW'(VALUE_BITS);
              state_nxt = S_CONV;
            end
            itr_pkg::KIND_HEX: begin
              sh_nxt    = SW'(HW'(q_mag)) << (SW - HW);
              cnt_nxt   = CW'(NHEX);
              state_nxt = S_SKIP;
            end
            itr_pkg::KIND_BIN: begin
              sh_nxt    = SW'(q_mag) << (SW - VALUE_BITS);
              cnt_nxt   = CW'(VALUE_BITS);
              state_nxt = S_SKIP;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        sh_nxt  = {adj[SW-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          cnt_nxt   = CW'(NDEC);
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (cnt_r > CW'(1) && cur_dig == 4'd0) begin
          sh_nxt  = sh_shift;
          cnt_nxt = cnt_r - CW'(1);
        end else if (neg_r) begin
          state_nxt = S_SIGN;
        end else if (kind_r == itr_pkg::KIND_DEC) begin
          state_nxt = S_DIG;
        end else begin
          state_nxt = S_PFX0;
        end
      end
      S_SIGN: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = itr_pkg::CHAR_MINUS;
          state_nxt = (kind_r == itr_pkg::KIND_DEC) ? S_DIG : S_PFX0;
        end
      end
      S_PFX0: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = itr_pkg::CHAR_ZERO;
          state_nxt = S_PFX1;
        end
      end
      S_PFX1: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = (kind_r == itr_pkg::KIND_BIN) ? itr_pkg::CHAR_B : itr_pkg::CHAR_X;
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = itr_pkg::digit_char(cur_dig);
          emit_last = (cnt_r == CW'(1));
          sh_nxt    = sh_shift;
          cnt_nxt   = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CHR: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_char = sh_r[7:0];
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    neg_r  <= neg_nxt;
    sh_r   <= sh_nxt;
    bin_r  <= bin_nxt;
    cnt_r  <= cnt_nxt;
    if (emit) begin
      out_char_r <= emit_char;
      out_last_r <= emit_last;
    end
  end

  assign out_item.valid      = out_vld_r;
  assign out_item.ascii_char = out_char_r;
  assign out_item.last_char  = out_last_r;

endmodule

// ----- rtl/itr_checker.sv -----
// Port-level checks for integer_to_radix_ascii, attached with a bind.
// Depends on itr_pkg for character constants.
module itr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_ascii_char,
  input logic       out_last_char
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ascii_char) && $stable(out_last_char))
    else $error("stalled output item changed");

  a_mid_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_char |->
      (out_ascii_char >= itr_pkg::CHAR_ZERO && out_ascii_char <= itr_pkg::CHAR_NINE) ||
      (out_ascii_char >= itr_pkg::CHAR_LA && out_ascii_char <= itr_pkg::CHAR_LF) ||
      (out_ascii_char == itr_pkg::CHAR_X) || (out_ascii_char == itr_pkg::CHAR_MINUS))
    else $error("unexpected character before end of directive");

endmodule

bind integer_to_radix_ascii itr_checker u_itr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_item.valid),
  .out_ready      (out_item.ready),
  .out_ascii_char (out_item.ascii_char),
  .out_last_char  (out_item.last_char)
);
